/* rtl/core/moving_average_warmup_unit_defines.svh */
// assertion macros for the moving average warm-up unit
// used by the top level only, no other dependencies
`ifndef MOVING_AVERAGE_WARMUP_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_WARMUP_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MAVG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mavg check failed");

// next-cycle implication, checked outside reset
`define MAVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mavg check failed");

`endif

/* rtl/core/mavg_pkg.sv */
// shared constants and types for the moving average warm-up unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int SAMPLE_W  = 24;
  localparam int FILLED_W  = 4;

  localparam logic CMD_PUSH    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

/* rtl/core/moving_average_warmup_unit.sv */
// boxcar moving average with warm-up: push returns the mean of the filled entries.
// a push passes through the read, add, divide and hand-off states to a valid result, the
// serial divider taking one quotient bit per cycle on the 27-bit total at DEPTH 8.
// one item at a time: in_ready is high only while idle, and rises in the same cycle as out_valid.
// synchronous active-low reset clears slot, fill count, total and handshakes; the ring
// is not cleared. depends on mavg_pkg, mavg_ring, mavg_div and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "moving_average_warmup_unit_defines.svh"

module moving_average_warmup_unit #(
  parameter int DEPTH = mavg_pkg::DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_command,
  input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [mavg_pkg::SAMPLE_W-1:0]      out_average,
  output logic [mavg_pkg::FILLED_W-1:0]             out_filled
);

  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // sum of DEPTH samples never leaves this signed width
  localparam int TOTAL_W = mavg_pkg::SAMPLE_W + $clog2(DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a transfer
  localparam logic [2:0] S_READ = 3'd1;  // oldest entry arrives, take it off once full
  localparam logic [2:0] S_ADD  = 3'd2;  // add the new sample, store it, start divide
  localparam logic [2:0] S_DIV  = 3'd3;  // divider at work
  localparam logic [2:0] S_PUT  = 3'd4;  // hand the mean to the output register

  logic [2:0]                          state_r, state_nxt;
  logic [SLOT_W-1:0]                   slot_r, slot_nxt;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt;
  logic signed [TOTAL_W-1:0]           total_r, total_nxt;
  logic signed [mavg_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [mavg_pkg::SAMPLE_W-1:0] out_average_r;
  logic [mavg_pkg::FILLED_W-1:0]       out_filled_r;

  logic                                 full;
  logic                                 in_xfer;
  logic                                 out_free;
  logic                                 rd_en;
  logic                                 wr_en;
  logic signed [mavg_pkg::SAMPLE_W-1:0] rd_data;
  logic                                 div_start;
  logic signed [TOTAL_W-1:0]            quotient;
  mavg_pkg::div_status_t                div_status;
  logic [CNT_W+mavg_pkg::FILLED_W-1:0]  cnt_ext;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // filled is the count seen through a 4-bit window
  assign cnt_ext = {{mavg_pkg::FILLED_W{1'b0}}, cnt_r};

  // read the slot about to be overwritten as the push is taken
  assign rd_en = in_xfer && (in_command == mavg_pkg::CMD_PUSH);
  assign wr_en = (state_r == S_ADD);

  always_comb begin
    state_nxt  = state_r;
    slot_nxt   = slot_r;
    cnt_nxt    = cnt_r;
    total_nxt  = total_r;
    sample_nxt = sample_r;
    div_start  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_command == mavg_pkg::CMD_RESTART) begin
            // restart history, no result
            slot_nxt  = '0;
            cnt_nxt   = '0;
            total_nxt = '0;
          end else begin
            sample_nxt = in_sample;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        // once full, the oldest entry leaves the window
        if (full) begin
          total_nxt = total_r - TOTAL_W'(rd_data);
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        total_nxt = total_r + TOTAL_W'(sample_r);
        if (!full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        slot_nxt  = (slot_r == SLOT_W'(DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_status.done) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        // wait here if the previous result has not been taken yet
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_PUT && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    if (state_r == S_PUT && out_free) begin
      out_average_r <= quotient[mavg_pkg::SAMPLE_W-1:0];
      out_filled_r  <= cnt_ext[mavg_pkg::FILLED_W-1:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_filled  = out_filled_r;

  mavg_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (sample_r),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // total over count; the count is never zero when a divide starts
  mavg_div #(
    .DEND_W (TOTAL_W),
    .DSOR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_nxt),
    .divisor  (cnt_nxt),
    .quotient (quotient),
    .status   (div_status)
  );

  // fill count saturates at the depth and the slot stays inside the ring
  `MAVG_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1,
                    (cnt_r <= CNT_W'(DEPTH)) && (slot_r <= SLOT_W'(DEPTH - 1)))
  // a new result only appears after the hand-off state
  `MAVG_ASSERT_IMPL(a_out_from_put, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_PUT)
  // a push goes on to fetch the oldest entry
  `MAVG_ASSERT_NEXT(a_push_reads, clk, rst_n,
                    in_xfer && (in_command == mavg_pkg::CMD_PUSH), state_r == S_READ)
  // the divider is only started while idle and never when the count is zero
  `MAVG_ASSERT_IMPL(a_div_start, clk, rst_n, div_start,
                    !div_status.busy && (cnt_nxt != '0))

endmodule

`default_nettype wire

/* rtl/core/mavg_ring.sv */
// history ring of samples, one write and one registered read per cycle
// depends on mavg_pkg for the sample width
`timescale 1ns / 1ps
`default_nettype none

module mavg_ring #(
  parameter int DEPTH = mavg_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  wire logic signed [mavg_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic                                rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [mavg_pkg::SAMPLE_W-1:0]      rd_data
);

  logic signed [mavg_pkg::SAMPLE_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mavg_div.sv */
// serial signed divider, restoring, one quotient bit per cycle
// truncates toward zero; depends on mavg_pkg for the status struct
`timescale 1ns / 1ps
`default_nettype none

module mavg_div #(
  parameter int DEND_W = 27,
  parameter int DSOR_W = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [DEND_W-1:0] dividend,
  input  wire logic [DSOR_W-1:0]        divisor,
  output logic signed [DEND_W-1:0]      quotient,
  output mavg_pkg::div_status_t         status
);

  localparam int STEP_W = $clog2(DEND_W + 1);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_ABS  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;
  localparam logic [1:0] D_FIX  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DEND_W-1:0] quo_r, quo_nxt;
  logic [DSOR_W-1:0] rem_r, rem_nxt;
  logic [DSOR_W-1:0] dsor_r, dsor_nxt;
  logic              neg_r, neg_nxt;
  logic              done_r, done_nxt;
  logic [DSOR_W:0]   rem_sh;
  logic [DSOR_W:0]   diff;
  logic              take;

  assign rem_sh = {rem_r, quo_r[DEND_W-1]};
  assign diff   = rem_sh - {1'b0, dsor_r};
  assign take   = !diff[DSOR_W];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dsor_nxt  = dsor_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          quo_nxt   = dividend;
          dsor_nxt  = divisor;
          neg_nxt   = dividend[DEND_W-1];
          state_nxt = D_ABS;
        end
      end
      D_ABS: begin
        // magnitude of the dividend, the most negative value fits unsigned
        if (neg_r) begin
          quo_nxt = -quo_r;
        end
        rem_nxt   = '0;
        step_nxt  = STEP_W'(DEND_W);
        state_nxt = D_RUN;
      end
      D_RUN: begin
        rem_nxt  = take ? diff[DSOR_W-1:0] : rem_sh[DSOR_W-1:0];
        quo_nxt  = {quo_r[DEND_W-2:0], take};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = D_FIX;
        end
      end
      D_FIX: begin
        if (neg_r) begin
          quo_nxt = -quo_r;
        end
        done_nxt  = 1'b1;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
    neg_r  <= neg_nxt;
  end

  assign quotient    = quo_r;
  assign status.busy = (state_r != D_IDLE);
  assign status.done = done_r;

endmodule

`default_nettype wire
